@@ src/dito_pkg.sv @@
// ----------------------------------------------------------------------------
// dito_pkg
// Shared types, codes and decode helpers for the delta id/offset table decoder.
// ----------------------------------------------------------------------------
package dito_pkg;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_ID,
      PH_OFF,
      PH_DIV,
      PH_MUL
   } phase_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   localparam logic       REG_POINTER_SIZE = 1'b0;
   localparam logic       REG_ENTRY_COUNT  = 1'b1;

   localparam logic       STATUS_OK     = 1'b0;
   localparam logic       STATUS_BAD_ID = 1'b1;

   localparam logic [3:0] ID_CODE_MAX = 4'd7;

   localparam logic [2:0] CODE_RAW64 = 3'd0;
   localparam logic [2:0] CODE_INC   = 3'd1;
   localparam logic [2:0] CODE_ADD8  = 3'd2;
   localparam logic [2:0] CODE_SUB8  = 3'd3;
   localparam logic [2:0] CODE_ADD16 = 3'd4;
   localparam logic [2:0] CODE_SUB16 = 3'd5;
   localparam logic [2:0] CODE_RAW16 = 3'd6;
   localparam logic [2:0] CODE_RAW32 = 3'd7;

   function automatic logic [3:0] code_len(input logic [2:0] code);
      logic [3:0] len;
      unique case (code)
         CODE_RAW64: len = 4'd8;
         CODE_INC:   len = 4'd0;
         CODE_ADD8,
         CODE_SUB8:  len = 4'd1;
         CODE_RAW32: len = 4'd4;
         default:    len = 4'd2;
      endcase
      return len;
   endfunction

   function automatic logic [63:0] apply_code(input logic [2:0]  code,
                                              input logic [63:0] base,
                                              input logic [63:0] value);
      logic [63:0] res;
      unique case (code)
         CODE_INC:   res = base + 64'd1;
         CODE_ADD8,
         CODE_ADD16: res = base + value;
         CODE_SUB8,
         CODE_SUB16: res = base - value;
         default:    res = value;
      endcase
      return res;
   endfunction

endpackage

@@ src/dito_div.sv @@
// ----------------------------------------------------------------------------
// dito_div
// Restoring divider, 64-bit dividend by 5-bit divisor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module dito_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [63:0]              dividend,
   input  logic [4:0]               divisor,
   output dito_pkg::div_status_type status,
   output logic [63:0]              quotient
);

   logic [63:0] quo_ff, quo_in;
   logic [4:0]  rem_ff, rem_in;
   logic [4:0]  dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  rem_sh;
   logic [5:0]  rem_sub;
   logic        ge;

   assign rem_sh  = {rem_ff, quo_ff[63]};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};
   assign ge      = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = 5'd0;
         dvs_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? rem_sub[4:0] : rem_sh[4:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

@@ src/delta_id_offset_table_decoder_core.sv @@
// ----------------------------------------------------------------------------
// delta_id_offset_table_decoder_core
// Byte-serial decoder for delta-coded id/offset table entries.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_stream_byte
//   rsp       out        rsp_valid/rsp_ready  rsp_entry_id, rsp_entry_offset,
//                                             rsp_status, rsp_last
//   csr       in         psel/penable/pready  paddr, pwdata, prdata
//
// One byte per cycle while the output register is free. An entry with bit 7
// of its type byte set runs the divider, then apply and scale, req_ready low.
// Synchronous reset; no clearing pass. The result sits in an output register;
// a byte is taken only when that register is empty or being drained.
// ----------------------------------------------------------------------------
module delta_id_offset_table_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_entry_id,
   output logic [63:0] rsp_entry_offset,
   output logic        rsp_status,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   dito_pkg::phase_type      phase_ff, phase_in;
   dito_pkg::div_status_type div_sts;

   logic [4:0]  ps_ff;
   logic [30:0] count_ff;
   logic [7:0]  type_ff, type_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  bl_ff, bl_in;
   logic [63:0] prev_id_ff, prev_id_in;
   logic [63:0] prev_off_ff, prev_off_in;
   logic [63:0] pend_ff, pend_in;
   logic [30:0] done_ff, done_in;
   logic        stopped_ff, stopped_in;
   logic [63:0] scaled_ff, scaled_in;

   logic        rsp_valid_ff;
   logic [63:0] rsp_id_ff, rsp_off_ff;
   logic        rsp_status_ff, rsp_last_ff;

   logic        emit;
   logic [63:0] emit_id, emit_off;
   logic        emit_status, emit_last;

   logic        out_free, take, active, fin, div_start;
   logic [7:0]  type_cur;
   logic [63:0] acc_cur, acc_new, shift_byte;
   logic [3:0]  len_cur;
   logic [2:0]  pos;
   logic [4:0]  ps_eff;
   logic [63:0] prod;
   logic [30:0] done_next;
   logic [63:0] quotient;
   logic        csr_wr;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff    <= 5'd8;
         count_ff <= 31'd0;
      end else if (csr_wr) begin
         if (paddr[2] == dito_pkg::REG_POINTER_SIZE) begin
            ps_ff <= pwdata[4:0];
         end else begin
            count_ff <= pwdata[30:0];
         end
      end
   end

   assign prdata = (paddr[2] == dito_pkg::REG_ENTRY_COUNT) ? {1'b0, count_ff}
                                                            : {27'd0, ps_ff};

   assign ps_eff     = (ps_ff == 5'd0) ? 5'd1 : ps_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = out_free && ((phase_ff == dito_pkg::PH_TYPE) ||
                                    (phase_ff == dito_pkg::PH_ID)   ||
                                    (phase_ff == dito_pkg::PH_OFF));
   assign active     = !stopped_ff && (done_ff < count_ff);
   assign take       = req_valid && req_ready && active;
   assign done_next  = done_ff + 31'd1;
   assign len_cur    = dito_pkg::code_len((phase_ff == dito_pkg::PH_OFF) ? type_ff[6:4]
                                                                         : type_ff[2:0]);
   assign pos        = 3'(len_cur - bl_ff);
   assign shift_byte = {56'd0, req_stream_byte} << {pos, 3'b000};
   assign acc_new    = acc_ff | shift_byte;
   assign prod       = scaled_ff * {59'd0, ps_eff};

   dito_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prev_off_ff),
      .divisor  (ps_eff),
      .status   (div_sts),
      .quotient (quotient)
   );

   always_comb begin
      phase_in    = phase_ff;
      type_in     = type_ff;
      acc_in      = acc_ff;
      bl_in       = bl_ff;
      prev_id_in  = prev_id_ff;
      prev_off_in = prev_off_ff;
      pend_in     = pend_ff;
      done_in     = done_ff;
      stopped_in  = stopped_ff;
      scaled_in   = scaled_ff;
      fin         = 1'b0;
      type_cur    = type_ff;
      acc_cur     = 64'd0;
      div_start   = 1'b0;
      emit        = 1'b0;
      emit_id     = pend_ff;
      emit_off    = 64'd0;
      emit_status = dito_pkg::STATUS_OK;
      emit_last   = 1'b0;

      unique case (phase_ff)
         dito_pkg::PH_TYPE: begin
            if (take) begin
               type_in  = req_stream_byte;
               type_cur = req_stream_byte;
               acc_in   = 64'd0;
               if (req_stream_byte[3:0] > dito_pkg::ID_CODE_MAX) begin
                  stopped_in  = 1'b1;
                  emit        = 1'b1;
                  emit_id     = 64'd0;
                  emit_status = dito_pkg::STATUS_BAD_ID;
                  emit_last   = 1'b1;
               end else if (dito_pkg::code_len(req_stream_byte[2:0]) == 4'd0) begin
                  pend_in = dito_pkg::apply_code(req_stream_byte[2:0], prev_id_ff, 64'd0);
                  if (dito_pkg::code_len(req_stream_byte[6:4]) == 4'd0) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = dito_pkg::PH_OFF;
                     bl_in    = dito_pkg::code_len(req_stream_byte[6:4]);
                  end
               end else begin
                  phase_in = dito_pkg::PH_ID;
                  bl_in    = dito_pkg::code_len(req_stream_byte[2:0]);
               end
            end
         end
         dito_pkg::PH_ID: begin
            if (take) begin
               bl_in = bl_ff - 4'd1;
               if (bl_ff == 4'd1) begin
                  pend_in = dito_pkg::apply_code(type_ff[2:0], prev_id_ff, acc_new);
                  acc_in  = 64'd0;
                  if (dito_pkg::code_len(type_ff[6:4]) == 4'd0) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = dito_pkg::PH_OFF;
                     bl_in    = dito_pkg::code_len(type_ff[6:4]);
                  end
               end else begin
                  acc_in = acc_new;
               end
            end
         end
         dito_pkg::PH_OFF: begin
            if (take) begin
               bl_in  = bl_ff - 4'd1;
               acc_in = acc_new;
               if (bl_ff == 4'd1) begin
                  fin     = 1'b1;
                  acc_cur = acc_new;
               end
            end
         end
         dito_pkg::PH_DIV: begin
            if (div_sts.done) begin
               scaled_in = dito_pkg::apply_code(type_ff[6:4], quotient, acc_ff);
               phase_in  = dito_pkg::PH_MUL;
            end
         end
         dito_pkg::PH_MUL: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_id     = pend_ff;
               emit_off    = prod[63:0];
               emit_last   = (done_next == count_ff);
               prev_id_in  = pend_ff;
               prev_off_in = prod[63:0];
               done_in     = done_next;
               phase_in    = dito_pkg::PH_TYPE;
               acc_in      = 64'd0;
               bl_in       = 4'd0;
            end
         end
         default: begin
            phase_in = dito_pkg::PH_TYPE;
         end
      endcase

      if (fin) begin
         if (type_cur[7]) begin
            div_start = 1'b1;
            acc_in    = acc_cur;
            phase_in  = dito_pkg::PH_DIV;
         end else begin
            emit        = 1'b1;
            emit_id     = pend_in;
            emit_off    = dito_pkg::apply_code(type_cur[6:4], prev_off_ff, acc_cur);
            emit_last   = (done_next == count_ff);
            prev_id_in  = pend_in;
            prev_off_in = emit_off;
            done_in     = done_next;
            phase_in    = dito_pkg::PH_TYPE;
            acc_in      = 64'd0;
            bl_in       = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dito_pkg::PH_TYPE;
         type_ff      <= 8'd0;
         acc_ff       <= 64'd0;
         bl_ff        <= 4'd0;
         prev_id_ff   <= 64'd0;
         prev_off_ff  <= 64'd0;
         pend_ff      <= 64'd0;
         done_ff      <= 31'd0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         type_ff      <= type_in;
         acc_ff       <= acc_in;
         bl_ff        <= bl_in;
         prev_id_ff   <= prev_id_in;
         prev_off_ff  <= prev_off_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         stopped_ff   <= stopped_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      scaled_ff <= scaled_in;
      if (emit) begin
         rsp_id_ff     <= emit_id;
         rsp_off_ff    <= emit_off;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_id     = rsp_id_ff;
   assign rsp_entry_offset = rsp_off_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // assertions
   a_no_req_while_div: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dito_pkg::PH_DIV || phase_ff == dito_pkg::PH_MUL) |-> !req_ready)
      else $error("byte taken during scaled offset computation");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> rsp_last)
      else $error("error transaction not marked last");

   a_div_done_phase: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (phase_ff == dito_pkg::PH_DIV))
      else $error("divider finished outside divide phase");

   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stop flag cleared without reset");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwrote pending transaction");

endmodule

@@ verif/dito_entry_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dito_entry_checker
// Watches the byte, result and register channels of the table decoder, keeps
// its own copy of the decode state, predicts every entry and error result,
// and compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module dito_entry_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_entry_id,
   input  logic [63:0] rsp_entry_offset,
   input  logic        rsp_status,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);

   localparam logic [2:0] ADDR_POINTER_SIZE = {dito_pkg::REG_POINTER_SIZE, 2'b00};
   localparam logic [2:0] ADDR_ENTRY_COUNT  = {dito_pkg::REG_ENTRY_COUNT, 2'b00};

   typedef struct packed {
      logic [63:0] id;
      logic [63:0] offset;
      logic        status;
      logic        last;
   } entry_result_type;

   entry_result_type expected_entries[$];

   logic [4:0]  ptr_size;
   logic [30:0] entry_limit;

   dito_pkg::phase_type ph;
   logic [7:0]  type_code;
   logic [63:0] acc;
   logic [3:0]  left;
   logic [63:0] prev_id;
   logic [63:0] prev_off;
   logic [63:0] pend_id;
   logic [30:0] done_cnt;
   logic        stopped;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic logic [3:0] field_bytes(input logic [2:0] code);
      case (code)
         dito_pkg::CODE_RAW64:                     return 4'd8;
         dito_pkg::CODE_INC:                       return 4'd0;
         dito_pkg::CODE_ADD8, dito_pkg::CODE_SUB8: return 4'd1;
         dito_pkg::CODE_RAW32:                     return 4'd4;
         default:                                  return 4'd2;
      endcase
   endfunction

   function automatic logic [63:0] combine(input logic [2:0] code, input logic [63:0] base,
                                           input logic [63:0] v);
      case (code)
         dito_pkg::CODE_INC:                         return base + 64'd1;
         dito_pkg::CODE_ADD8, dito_pkg::CODE_ADD16:  return base + v;
         dito_pkg::CODE_SUB8, dito_pkg::CODE_SUB16:  return base - v;
         default:                                    return v;
      endcase
   endfunction

   function automatic void finish_entry(output entry_result_type r);
      logic [63:0] divisor;
      logic [63:0] base;
      logic [63:0] off;
      divisor  = (ptr_size == 5'd0) ? 64'd1 : 64'(ptr_size);
      base     = type_code[7] ? prev_off / divisor : prev_off;
      off      = combine(type_code[6:4], base, acc);
      if (type_code[7])
         off = off * divisor;
      prev_id  = pend_id;
      prev_off = off;
      done_cnt = done_cnt + 31'd1;
      r.id     = pend_id;
      r.offset = off;
      r.status = dito_pkg::STATUS_OK;
      r.last   = (done_cnt == entry_limit);
      ph       = dito_pkg::PH_TYPE;
      acc      = '0;
      left     = '0;
   endfunction

   function automatic bit begin_offset(output entry_result_type r);
      acc  = '0;
      left = field_bytes(type_code[6:4]);
      if (left == 4'd0) begin
         finish_entry(r);
         return 1'b1;
      end
      ph = dito_pkg::PH_OFF;
      return 1'b0;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, output entry_result_type r);
      logic [2:0] pos;
      r = '0;
      if (stopped || done_cnt >= entry_limit)
         return 1'b0;
      case (ph)
         dito_pkg::PH_TYPE: begin
            type_code = b;
            if (b[3:0] > dito_pkg::ID_CODE_MAX) begin
               stopped  = 1'b1;
               r.status = dito_pkg::STATUS_BAD_ID;
               r.last   = 1'b1;
               return 1'b1;
            end
            acc  = '0;
            left = field_bytes(b[2:0]);
            if (left == 4'd0) begin
               pend_id = combine(b[2:0], prev_id, 64'd0);
               return begin_offset(r);
            end
            ph = dito_pkg::PH_ID;
            return 1'b0;
         end
         dito_pkg::PH_ID: begin
            pos  = 3'(field_bytes(type_code[2:0]) - left);
            acc  = acc | (64'(b) << (8 * pos));
            left = left - 4'd1;
            if (left == 4'd0) begin
               pend_id = combine(type_code[2:0], prev_id, acc);
               return begin_offset(r);
            end
            return 1'b0;
         end
         default: begin
            pos  = 3'(field_bytes(type_code[6:4]) - left);
            acc  = acc | (64'(b) << (8 * pos));
            left = left - 4'd1;
            if (left == 4'd0) begin
               finish_entry(r);
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      entry_result_type want;
      entry_result_type pred;
      if (reset) begin
         expected_entries.delete();
         ptr_size    = 5'd8;
         entry_limit = '0;
         ph          = dito_pkg::PH_TYPE;
         type_code   = '0;
         acc         = '0;
         left        = '0;
         prev_id     = '0;
         prev_off    = '0;
         pend_id     = '0;
         done_cnt    = '0;
         stopped     = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_entries.size() == 0) begin
               report_mismatch("unexpected transaction, entry_id", rsp_entry_id, '0);
            end else begin
               want = expected_entries.pop_front();
               if (rsp_entry_id !== want.id)
                  report_mismatch("entry_id", rsp_entry_id, want.id);
               if (rsp_entry_offset !== want.offset)
                  report_mismatch("entry_offset", rsp_entry_offset, want.offset);
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_POINTER_SIZE)
               ptr_size = pwdata[4:0];
            else if (paddr == ADDR_ENTRY_COUNT)
               entry_limit = pwdata[30:0];
         end
         if (req_valid && req_ready) begin
            if (decode_byte(req_stream_byte, pred))
               expected_entries.push_back(pred);
         end
      end
      pending = expected_entries.size();
   end

endmodule

@@ verif/tb_delta_id_offset_table_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_id_offset_table_decoder_core
// Drives byte streams of coded table entries into the decoder: a short
// directed set, then random entries over several pointer sizes and entry
// counts, with random idling on both channels and one long result stall.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_delta_id_offset_table_decoder_core;

   localparam logic [2:0]  ADDR_POINTER_SIZE = {dito_pkg::REG_POINTER_SIZE, 2'b00};
   localparam logic [2:0]  ADDR_ENTRY_COUNT  = {dito_pkg::REG_ENTRY_COUNT, 2'b00};
   localparam logic [31:0] ENTRY_COUNT_MAX   = 32'h7FFF_FFFF;
   localparam int          DRAIN_CYCLES      = 80;
   localparam int          HOLD_CYCLES       = 400;
   localparam int          WATCHDOG_LIMIT    = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_entry_id;
   logic [63:0] rsp_entry_offset;
   logic        rsp_status;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int entries_seen = 0;
   int mismatch_total;
   int expected_left;
   int ptr_plan [9];

   logic [7:0] outgoing_bytes[$];

   delta_id_offset_table_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_id     (rsp_entry_id),
      .rsp_entry_offset (rsp_entry_offset),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   dito_entry_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_id     (rsp_entry_id),
      .rsp_entry_offset (rsp_entry_offset),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .fail_count       (mismatch_total),
      .pending          (expected_left)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == dito_pkg::STATUS_OK)
         entries_seen <= entries_seen + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** delta_id_offset_table_decoder_core: FAILED **");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic stream_out(input int count);
      for (int i = 0; i < count && outgoing_bytes.size() > 0; i++)
         send_byte(outgoing_bytes.pop_front());
      req_valid <= 1'b0;
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic settle();
      while (expected_left != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_entry(input logic [7:0] kind, input logic [63:0] id_val,
                              input logic [63:0] off_val);
      logic [3:0] n;
      outgoing_bytes.push_back(kind);
      n = dito_pkg::code_len(kind[2:0]);
      for (int i = 0; i < n; i++)
         outgoing_bytes.push_back(id_val[8*i +: 8]);
      n = dito_pkg::code_len(kind[6:4]);
      for (int i = 0; i < n; i++)
         outgoing_bytes.push_back(off_val[8*i +: 8]);
   endtask

   task automatic queue_random_entry();
      logic [7:0]  kind;
      logic [63:0] id_val;
      logic [63:0] off_val;
      kind    = 8'($urandom);
      kind[3] = 1'b0;
      id_val  = {$urandom, $urandom};
      off_val = {$urandom, $urandom};
      if ($urandom_range(7) == 0)
         id_val = '1;
      if ($urandom_range(7) == 0)
         off_val = '1;
      queue_entry(kind, id_val, off_val);
   endtask

   initial begin
      logic [7:0] bad_type;
      ptr_plan = '{1, 16, 31, 8, 0, 17, 16, 1, 3};
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // entry count still zero: bytes dropped
      outgoing_bytes.push_back(8'h11);
      outgoing_bytes.push_back(8'h00);
      stream_out(outgoing_bytes.size());
      settle();

      csr_write(ADDR_ENTRY_COUNT, ENTRY_COUNT_MAX);
      csr_write(ADDR_POINTER_SIZE, 32'd0);
      queue_entry(8'h11, '0, '0);
      queue_entry(8'h90, '1, '0);
      queue_entry(8'h23, 64'hFF, 64'h80);
      queue_entry(8'hD5, 64'hFFFF, 64'h0001);
      queue_entry(8'h64, 64'h8000, 64'hFFFF);
      stream_out(outgoing_bytes.size());

      for (int p = 0; p < 9; p++) begin
         settle();
         send_idle_pct = (p < 3) ? 14 : (p < 6) ? 70 : 0;
         recv_idle_pct = (p < 3) ? 70 : (p < 6) ? 14 : 0;
         csr_write(ADDR_POINTER_SIZE, 32'(ptr_plan[p]));
         if (p == 2)
            csr_write(ADDR_ENTRY_COUNT, 32'(entries_seen + 500));
         if (p == 3)
            csr_write(ADDR_ENTRY_COUNT, ENTRY_COUNT_MAX);
         if (p == 4) begin
            // pointer size changed in the middle of a scaled entry
            queue_entry(8'hC0, {$urandom, $urandom}, 64'(16'($urandom)));
            stream_out(4);
            settle();
            csr_write(ADDR_POINTER_SIZE, 32'd5);
            stream_out(outgoing_bytes.size());
            settle();
         end
         if (p == 6)
            hold_asked++;
         if (p == 7) begin
            csr_write(ADDR_ENTRY_COUNT, 32'(entries_seen + 2));
            repeat (4) queue_random_entry();
            stream_out(outgoing_bytes.size());
            settle();
            csr_write(ADDR_ENTRY_COUNT, 32'(entries_seen / 2));
            repeat (2) queue_random_entry();
            stream_out(outgoing_bytes.size());
            settle();
            csr_write(ADDR_ENTRY_COUNT, ENTRY_COUNT_MAX);
         end
         while (outgoing_bytes.size() < 40)
            queue_random_entry();
         stream_out(outgoing_bytes.size());
      end

      // bad id code stops the decoder for good
      settle();
      send_idle_pct = 14;
      recv_idle_pct = 14;
      bad_type    = 8'($urandom);
      bad_type[3] = 1'b1;
      outgoing_bytes.push_back(bad_type);
      repeat (4) outgoing_bytes.push_back(8'($urandom));
      stream_out(outgoing_bytes.size());
      settle();

      if (mismatch_total == 0)
         $display("** delta_id_offset_table_decoder_core: PASSED **");
      else
         $display("** delta_id_offset_table_decoder_core: FAILED **");
      $finish;
   end

endmodule
